FILE: rtl/core/point_cloud_flex_conv_forward_macros.svh
// Assertion macros for the flex convolution block.
// Expects signals named clock and reset in the module that uses them.
`ifndef POINT_CLOUD_FLEX_CONV_FORWARD_MACROS_SVH
`define POINT_CLOUD_FLEX_CONV_FORWARD_MACROS_SVH

// same-cycle implication
`define PCFC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PCFC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/pcfc_pkg.sv
// Shared types, codes and constants of the flex convolution block.
// No dependencies.
`default_nettype none
package pcfc_pkg;

   localparam int MAX_POINTS       = 1024;
   localparam int MAX_NEIGHBORS    = 8;
   localparam int MAX_IN_CHANNELS  = 16;
   localparam int MAX_OUT_CHANNELS = 16;
   localparam int MAX_POS_DIMS     = 3;

   localparam int FEAT_DEPTH  = MAX_IN_CHANNELS * MAX_POINTS;
   localparam int POS_DEPTH   = MAX_POS_DIMS * MAX_POINTS;
   localparam int NBR_DEPTH   = MAX_NEIGHBORS * MAX_POINTS;
   localparam int SLOPE_DEPTH = MAX_POS_DIMS * MAX_IN_CHANNELS * MAX_OUT_CHANNELS;
   localparam int BIAS_DEPTH  = MAX_IN_CHANNELS * MAX_OUT_CHANNELS;

   // command codes
   typedef enum logic [2:0] {
      OP_FEATURE  = 3'd0,
      OP_POSITION = 3'd1,
      OP_NEIGHBOR = 3'd2,
      OP_SLOPE    = 3'd3,
      OP_BIAS     = 3'd4,
      OP_COMPUTE  = 3'd5
   } pcfc_op_type;

   // register indexes
   typedef enum logic [1:0] {
      REG_IN_CHANNELS    = 2'd0,
      REG_OUT_CHANNELS   = 2'd1,
      REG_NEIGHBOR_COUNT = 2'd2,
      REG_POS_DIMS       = 2'd3
   } pcfc_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CTR_RD,
      ST_CTR_LD,
      ST_SLOT_RD,
      ST_SLOT_LD,
      ST_CH_RD,
      ST_CH_LD,
      ST_DIM_RD,
      ST_DIM_DELTA,
      ST_DIM_MUL,
      ST_DIM_ACC,
      ST_W_SAT,
      ST_W_MUL,
      ST_W_ACC,
      ST_OUT
   } pcfc_state_type;

   // effective loop bounds, each minus one
   typedef struct packed {
      logic [3:0] nin_m1;
      logic [3:0] nout_m1;
      logic [2:0] nk_m1;
      logic [1:0] nd_m1;
   } pcfc_cfg_type;

   typedef struct packed {
      logic [2:0]        command;
      logic [9:0]        point;
      logic [2:0]        slot;
      logic [3:0]        in_channel;
      logic [3:0]        out_channel;
      logic [1:0]        coord;
      logic signed [31:0] value;
   } pcfc_req_type;

   typedef struct packed {
      logic wr_en;
      logic ptr_ld;
      logic center_ld;
      logic k_ld;
      logic ch_ld;
      logic dim_delta;
      logic dim_mul;
      logic dim_acc;
      logic w_sat;
      logic w_mul;
      logic w_acc;
      logic acc_clr;
      logic out_ld;
      logic last;
      logic [2:0] slot;
      logic [3:0] ich;
      logic [3:0] och;
      logic [1:0] dim;
   } pcfc_cmd_type;

   typedef struct packed {
      logic out_free;
   } pcfc_sts_type;

   // saturate a 64-bit signed value to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647)       r = 32'sh7FFF_FFFF;
      else if (x < -64'sd2147483648) r = 32'sh8000_0000;
      else                           r = x[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pcfc_req_if.sv
// Command channel interface of the flex convolution block.
// No dependencies.
`default_nettype none
interface pcfc_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         command;
   logic [9:0]         point;
   logic [2:0]         slot;
   logic [3:0]         in_channel;
   logic [3:0]         out_channel;
   logic [1:0]         coord;
   logic signed [31:0] value;

   modport source (output valid, command, point, slot, in_channel, out_channel, coord,
                   value, input ready);
   modport sink (input valid, command, point, slot, in_channel, out_channel, coord,
                 value, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pcfc_rsp_if.sv
// Result channel interface of the flex convolution block.
// No dependencies.
`default_nettype none
interface pcfc_rsp_if;
   logic               valid;
   logic               ready;
   logic [9:0]         point_res;
   logic [3:0]         out_channel_res;
   logic signed [31:0] result_value;
   logic               last;

   modport source (output valid, point_res, out_channel_res, result_value, last,
                   input ready);
   modport sink (input valid, point_res, out_channel_res, result_value, last,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/core/point_cloud_flex_conv_forward.sv
// Top level of the forward flex convolution block: register port and wiring.
// Depends on pcfc_pkg, pcfc_req_if, pcfc_rsp_if, pcfc_ctrl and pcfc_dpath.
//
//  channel   direction  handshake              payload
//  req_bus   in         valid/ready            command, point, slot, channels, coord, value
//  rsp_bus   out        valid/ready            point_res, out_channel_res, result_value, last
//  APB       in         psel/penable/pready    paddr, pwdata, prdata
//
// Store writes are taken while idle. A compute loops over output channels, neighbour
// slots, input channels and dimensions; its pace is set by the two multipliers
// (slope times delta, weight times feature) and the registered store reads.
// Reset is synchronous and clears control state and the registers; stores are not cleared.
// A result waits in the output register; the next channel stalls only if it is still full.
// Commands are taken only while no compute is running.
`default_nettype none
module point_cloud_flex_conv_forward (
   input  wire logic  clock,
   input  wire logic  reset,
   pcfc_req_if.sink   req_bus,
   pcfc_rsp_if.source rsp_bus,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [4:0] in_ch_ff, out_ch_ff;
   logic [3:0] nk_ff;
   logic [1:0] nd_ff;
   pcfc_pkg::pcfc_reg_type reg_sel;
   pcfc_pkg::pcfc_cfg_type cfg;
   pcfc_pkg::pcfc_req_type req;
   pcfc_pkg::pcfc_cmd_type cmd;
   pcfc_pkg::pcfc_sts_type sts;

   assign pready  = 1'b1;
   assign reg_sel = pcfc_pkg::pcfc_reg_type'(paddr[3:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         in_ch_ff  <= 5'd16;
         out_ch_ff <= 5'd16;
         nk_ff     <= 4'd8;
         nd_ff     <= 2'd3;
      end else if (psel && penable && pwrite) begin
         unique case (reg_sel)
            pcfc_pkg::REG_IN_CHANNELS:    in_ch_ff  <= pwdata[4:0];
            pcfc_pkg::REG_OUT_CHANNELS:   out_ch_ff <= pwdata[4:0];
            pcfc_pkg::REG_NEIGHBOR_COUNT: nk_ff     <= pwdata[3:0];
            pcfc_pkg::REG_POS_DIMS:       nd_ff     <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (reg_sel)
         pcfc_pkg::REG_IN_CHANNELS:    prdata = 32'(in_ch_ff);
         pcfc_pkg::REG_OUT_CHANNELS:   prdata = 32'(out_ch_ff);
         pcfc_pkg::REG_NEIGHBOR_COUNT: prdata = 32'(nk_ff);
         pcfc_pkg::REG_POS_DIMS:       prdata = 32'(nd_ff);
         default:                      prdata = '0;
      endcase
   end

   // clamp to 1..max, kept as count minus one
   always_comb begin
      if (in_ch_ff == 5'd0)       cfg.nin_m1 = 4'd0;
      else if (in_ch_ff > 5'd16)  cfg.nin_m1 = 4'd15;
      else                        cfg.nin_m1 = 4'(in_ch_ff - 5'd1);
      if (out_ch_ff == 5'd0)      cfg.nout_m1 = 4'd0;
      else if (out_ch_ff > 5'd16) cfg.nout_m1 = 4'd15;
      else                        cfg.nout_m1 = 4'(out_ch_ff - 5'd1);
      if (nk_ff == 4'd0)          cfg.nk_m1 = 3'd0;
      else if (nk_ff > 4'd8)      cfg.nk_m1 = 3'd7;
      else                        cfg.nk_m1 = 3'(nk_ff - 4'd1);
      if (nd_ff == 2'd0)          cfg.nd_m1 = 2'd0;
      else                        cfg.nd_m1 = nd_ff - 2'd1;
   end

   assign req.command     = req_bus.command;
   assign req.point       = req_bus.point;
   assign req.slot        = req_bus.slot;
   assign req.in_channel  = req_bus.in_channel;
   assign req.out_channel = req_bus.out_channel;
   assign req.coord       = req_bus.coord;
   assign req.value       = req_bus.value;

   pcfc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_bus.ready),
      .cmd         (cmd),
      .sts         (sts)
   );

   pcfc_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req                 (req),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_point_res       (rsp_bus.point_res),
      .rsp_out_channel_res (rsp_bus.out_channel_res),
      .rsp_result_value    (rsp_bus.result_value),
      .rsp_last            (rsp_bus.last)
   );

endmodule
`default_nettype wire

FILE: rtl/core/pcfc_dpath.sv
// Datapath: the five stores, the weight and feature MAC and the result register.
// Depends on pcfc_pkg.
`default_nettype none
module pcfc_dpath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pcfc_pkg::pcfc_req_type req,
   input  wire pcfc_pkg::pcfc_cmd_type cmd,
   output pcfc_pkg::pcfc_sts_type      sts,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [9:0]                  rsp_point_res,
   output logic [3:0]                  rsp_out_channel_res,
   output logic signed [31:0]          rsp_result_value,
   output logic                        rsp_last
);

   logic [31:0] feat_mem  [pcfc_pkg::FEAT_DEPTH];
   logic [31:0] pos_mem   [pcfc_pkg::POS_DEPTH];
   logic [9:0]  nbr_mem   [pcfc_pkg::NBR_DEPTH];
   logic [31:0] slope_mem [pcfc_pkg::SLOPE_DEPTH];
   logic [31:0] bias_mem  [pcfc_pkg::BIAS_DEPTH];

   logic [31:0] feat_rd_ff, posk_rd_ff, posc_rd_ff, slope_rd_ff, bias_rd_ff;
   logic [9:0]  nbr_rd_ff;

   logic [9:0]  point_ff, center_ff, k_ff;
   logic signed [31:0] f_ff, th_ff, delta_ff, ws_ff;
   logic signed [63:0] dprod_ff, wprod_ff, acc_ff;
   logic signed [49:0] w_ff;
   logic               rsp_valid_ff;
   logic [9:0]         rsp_point_ff;
   logic [3:0]         rsp_och_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_last_ff;

   pcfc_pkg::pcfc_op_type op;
   logic wr_feat, wr_pos, wr_nbr, wr_slope, wr_bias;
   logic signed [32:0] diff;
   logic signed [47:0] dprod_sh, wprod_sh;

   // write decode
   always_comb begin
      op       = pcfc_pkg::pcfc_op_type'(req.command);
      wr_feat  = 1'b0;
      wr_pos   = 1'b0;
      wr_nbr   = 1'b0;
      wr_slope = 1'b0;
      wr_bias  = 1'b0;
      if (cmd.wr_en) begin
         case (op)
            pcfc_pkg::OP_FEATURE:  wr_feat  = 1'b1;
            pcfc_pkg::OP_POSITION: wr_pos   = (req.coord != 2'd3);
            pcfc_pkg::OP_NEIGHBOR: wr_nbr   = 1'b1;
            pcfc_pkg::OP_SLOPE:    wr_slope = (req.coord != 2'd3);
            pcfc_pkg::OP_BIAS:     wr_bias  = 1'b1;
            default: ;
         endcase
      end
   end

   // stores, read data registered
   always_ff @(posedge clock) begin
      if (wr_feat) feat_mem[{req.in_channel, req.point}] <= req.value;
      feat_rd_ff <= feat_mem[{cmd.ich, k_ff}];
   end

   always_ff @(posedge clock) begin
      if (wr_pos) pos_mem[{req.coord, req.point}] <= req.value;
      posk_rd_ff <= pos_mem[{cmd.dim, k_ff}];
      posc_rd_ff <= pos_mem[{cmd.dim, center_ff}];
   end

   always_ff @(posedge clock) begin
      if (wr_nbr) nbr_mem[{req.slot, req.point}] <= req.value[9:0];
      nbr_rd_ff <= nbr_mem[{cmd.slot, point_ff}];
   end

   always_ff @(posedge clock) begin
      if (wr_slope) slope_mem[{req.coord, req.in_channel, req.out_channel}] <= req.value;
      slope_rd_ff <= slope_mem[{cmd.dim, cmd.ich, cmd.och}];
   end

   always_ff @(posedge clock) begin
      if (wr_bias) bias_mem[{req.in_channel, req.out_channel}] <= req.value;
      bias_rd_ff <= bias_mem[{cmd.ich, cmd.och}];
   end

   // arithmetic helpers: difference and floor shifts
   always_comb begin
      diff     = $signed({posk_rd_ff[31], posk_rd_ff}) - $signed({posc_rd_ff[31], posc_rd_ff});
      dprod_sh = dprod_ff[63:16];
      wprod_sh = wprod_ff[63:16];
   end

   // MAC registers
   always_ff @(posedge clock) begin
      if (cmd.ptr_ld)    point_ff  <= req.point;
      if (cmd.center_ld) center_ff <= nbr_rd_ff;
      if (cmd.k_ld)      k_ff      <= nbr_rd_ff;
      if (cmd.ch_ld) begin
         w_ff <= 50'($signed(bias_rd_ff));
         f_ff <= $signed(feat_rd_ff);
      end
      if (cmd.dim_delta) begin
         delta_ff <= pcfc_pkg::sat32(64'(diff));
         th_ff    <= $signed(slope_rd_ff);
      end
      if (cmd.dim_mul) dprod_ff <= 64'(th_ff) * 64'(delta_ff);
      if (cmd.dim_acc) w_ff     <= w_ff + 50'(dprod_sh);
      if (cmd.w_sat)   ws_ff    <= pcfc_pkg::sat32(64'(w_ff));
      if (cmd.w_mul)   wprod_ff <= 64'(ws_ff) * 64'(f_ff);
      if (cmd.acc_clr)     acc_ff <= '0;
      else if (cmd.w_acc)  acc_ff <= acc_ff + 64'(wprod_sh);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         rsp_point_ff <= point_ff;
         rsp_och_ff   <= cmd.och;
         rsp_value_ff <= pcfc_pkg::sat32(acc_ff);
         rsp_last_ff  <= cmd.last;
      end
   end

   assign sts.out_free        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_point_res       = rsp_point_ff;
   assign rsp_out_channel_res = rsp_och_ff;
   assign rsp_result_value    = rsp_value_ff;
   assign rsp_last            = rsp_last_ff;

endmodule
`default_nettype wire

FILE: rtl/core/pcfc_ctrl.sv
// Controller: state machine and loop counters sequencing one compute.
// Depends on pcfc_pkg and the assertion macro header.
`default_nettype none
`include "point_cloud_flex_conv_forward_macros.svh"
module pcfc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pcfc_pkg::pcfc_cfg_type  cfg,
   input  wire logic                   req_valid,
   input  wire logic [2:0]             req_command,
   output logic                        req_ready,
   output pcfc_pkg::pcfc_cmd_type       cmd,
   input  wire pcfc_pkg::pcfc_sts_type  sts
);

   pcfc_pkg::pcfc_state_type state_ff, state_in;
   logic [2:0] s_ff, s_in;
   logic [3:0] i_ff, i_in;
   logic [3:0] o_ff, o_in;
   logic [1:0] d_ff, d_in;
   logic       is_compute, last_d, last_i, last_s, last_o;

   assign is_compute = (pcfc_pkg::pcfc_op_type'(req_command) == pcfc_pkg::OP_COMPUTE);
   assign last_d = (d_ff == cfg.nd_m1);
   assign last_i = (i_ff == cfg.nin_m1);
   assign last_s = (s_ff == cfg.nk_m1);
   assign last_o = (o_ff == cfg.nout_m1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcfc_pkg::ST_IDLE;
         s_ff <= '0;
         i_ff <= '0;
         o_ff <= '0;
         d_ff <= '0;
      end else begin
         state_ff <= state_in;
         s_ff <= s_in;
         i_ff <= i_in;
         o_ff <= o_in;
         d_ff <= d_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcfc_pkg::ST_IDLE:      if (req_valid && is_compute) state_in = pcfc_pkg::ST_CTR_RD;
         pcfc_pkg::ST_CTR_RD:    state_in = pcfc_pkg::ST_CTR_LD;
         pcfc_pkg::ST_CTR_LD:    state_in = pcfc_pkg::ST_SLOT_RD;
         pcfc_pkg::ST_SLOT_RD:   state_in = pcfc_pkg::ST_SLOT_LD;
         pcfc_pkg::ST_SLOT_LD:   state_in = pcfc_pkg::ST_CH_RD;
         pcfc_pkg::ST_CH_RD:     state_in = pcfc_pkg::ST_CH_LD;
         pcfc_pkg::ST_CH_LD:     state_in = pcfc_pkg::ST_DIM_RD;
         pcfc_pkg::ST_DIM_RD:    state_in = pcfc_pkg::ST_DIM_DELTA;
         pcfc_pkg::ST_DIM_DELTA: state_in = pcfc_pkg::ST_DIM_MUL;
         pcfc_pkg::ST_DIM_MUL:   state_in = pcfc_pkg::ST_DIM_ACC;
         pcfc_pkg::ST_DIM_ACC: begin
            state_in = last_d ? pcfc_pkg::ST_W_SAT : pcfc_pkg::ST_DIM_RD;
         end
         pcfc_pkg::ST_W_SAT:     state_in = pcfc_pkg::ST_W_MUL;
         pcfc_pkg::ST_W_MUL:     state_in = pcfc_pkg::ST_W_ACC;
         pcfc_pkg::ST_W_ACC: begin
            if (!last_i)     state_in = pcfc_pkg::ST_CH_RD;
            else if (!last_s) state_in = pcfc_pkg::ST_SLOT_RD;
            else             state_in = pcfc_pkg::ST_OUT;
         end
         pcfc_pkg::ST_OUT: begin
            if (sts.out_free) state_in = last_o ? pcfc_pkg::ST_IDLE : pcfc_pkg::ST_SLOT_RD;
         end
         default:                state_in = pcfc_pkg::ST_IDLE;
      endcase
   end

   // outputs and counters
   always_comb begin
      cmd       = '0;
      cmd.slot  = s_ff;
      cmd.ich   = i_ff;
      cmd.och   = o_ff;
      cmd.dim   = d_ff;
      cmd.last  = last_o;
      req_ready = 1'b0;
      s_in = s_ff;
      i_in = i_ff;
      o_in = o_ff;
      d_in = d_ff;
      unique case (state_ff)
         pcfc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.wr_en = req_valid;
            if (req_valid && is_compute) begin
               cmd.ptr_ld = 1'b1;
               s_in = '0;
               i_in = '0;
               o_in = '0;
               d_in = '0;
            end
         end
         pcfc_pkg::ST_CTR_LD: begin
            cmd.center_ld = 1'b1;
            cmd.acc_clr   = 1'b1;
         end
         pcfc_pkg::ST_SLOT_LD:   cmd.k_ld      = 1'b1;
         pcfc_pkg::ST_CH_LD:     cmd.ch_ld     = 1'b1;
         pcfc_pkg::ST_DIM_DELTA: cmd.dim_delta = 1'b1;
         pcfc_pkg::ST_DIM_MUL:   cmd.dim_mul   = 1'b1;
         pcfc_pkg::ST_DIM_ACC: begin
            cmd.dim_acc = 1'b1;
            d_in = last_d ? 2'd0 : d_ff + 2'd1;
         end
         pcfc_pkg::ST_W_SAT:     cmd.w_sat = 1'b1;
         pcfc_pkg::ST_W_MUL:     cmd.w_mul = 1'b1;
         pcfc_pkg::ST_W_ACC: begin
            cmd.w_acc = 1'b1;
            i_in = last_i ? 4'd0 : i_ff + 4'd1;
            if (last_i) s_in = last_s ? 3'd0 : s_ff + 3'd1;
         end
         pcfc_pkg::ST_OUT: begin
            if (sts.out_free) begin
               cmd.out_ld  = 1'b1;
               cmd.acc_clr = 1'b1;
               o_in = o_ff + 4'd1;
            end
         end
         default: ;
      endcase
   end

   `PCFC_ASSERT_NEXT(a_compute_start, (state_ff == pcfc_pkg::ST_IDLE && req_valid && is_compute), (state_ff == pcfc_pkg::ST_CTR_RD), "compute accepted without starting")
   `PCFC_ASSERT_SAME(a_out_room, cmd.out_ld, sts.out_free, "result loaded over a waiting one")
   `PCFC_ASSERT_NEXT(a_last_ends, (cmd.out_ld && cmd.last), (state_ff == pcfc_pkg::ST_IDLE), "run did not end on last channel")

endmodule
`default_nettype wire

FILE: tb/sv/point_cloud_flex_conv_forward_tb.sv
// Self-checking testbench for the forward flex convolution block.
// Depends on pcfc_pkg, pcfc_req_if, pcfc_rsp_if and point_cloud_flex_conv_forward.
`timescale 1ns / 1ps

module point_cloud_flex_conv_forward_tb;

   // commands that the block ignores, and the coordinate beyond the last dimension
   localparam logic [2:0] OP_SPARE_A  = 3'd6;
   localparam logic [2:0] OP_SPARE_B  = 3'd7;
   localparam logic [1:0] COORD_SPARE = 2'd3;

   typedef struct {
      logic [9:0]         pt;
      logic [3:0]         och;
      logic signed [31:0] val;
      logic               last;
   } conv_result_type;

   // Holds a copy of every store and register, and the outputs still owed
   class flex_conv_scoreboard;
      logic signed [31:0] feat_mem [pcfc_pkg::FEAT_DEPTH];
      logic signed [31:0] pos_mem [pcfc_pkg::POS_DEPTH];
      logic [9:0]         nbr_mem [pcfc_pkg::NBR_DEPTH];
      logic signed [31:0] slope_mem [pcfc_pkg::SLOPE_DEPTH];
      logic signed [31:0] bias_mem [pcfc_pkg::BIAS_DEPTH];
      bit feat_set [pcfc_pkg::FEAT_DEPTH];
      bit pos_set [pcfc_pkg::POS_DEPTH];
      bit nbr_set [pcfc_pkg::NBR_DEPTH];
      bit slope_set [pcfc_pkg::SLOPE_DEPTH];
      bit bias_set [pcfc_pkg::BIAS_DEPTH];
      logic [4:0] reg_in, reg_out;
      logic [3:0] reg_nk;
      logic [1:0] reg_dims;
      conv_result_type owed_q[$];
      int errors, results, computes, items;

      function new();
         reg_in = 5'd16; reg_out = 5'd16; reg_nk = 4'd8; reg_dims = 2'd3;
      endfunction

      function int clamp_reg(int r, int mx);
         if (r < 1) return 1;
         return (r > mx) ? mx : r;
      endfunction

      function int n_in();
         return clamp_reg(int'(reg_in), pcfc_pkg::MAX_IN_CHANNELS);
      endfunction
      function int n_out();
         return clamp_reg(int'(reg_out), pcfc_pkg::MAX_OUT_CHANNELS);
      endfunction
      function int n_nk();
         return clamp_reg(int'(reg_nk), pcfc_pkg::MAX_NEIGHBORS);
      endfunction
      function int n_dims();
         return clamp_reg(int'(reg_dims), pcfc_pkg::MAX_POS_DIMS);
      endfunction

      function longint sat_word(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      function void set_reg(pcfc_pkg::pcfc_reg_type idx, logic [31:0] v);
         case (idx)
            pcfc_pkg::REG_IN_CHANNELS:    reg_in = v[4:0];
            pcfc_pkg::REG_OUT_CHANNELS:   reg_out = v[4:0];
            pcfc_pkg::REG_NEIGHBOR_COUNT: reg_nk = v[3:0];
            pcfc_pkg::REG_POS_DIMS:       reg_dims = v[1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(pcfc_pkg::pcfc_reg_type idx);
         case (idx)
            pcfc_pkg::REG_IN_CHANNELS:    return 32'(reg_in);
            pcfc_pkg::REG_OUT_CHANNELS:   return 32'(reg_out);
            pcfc_pkg::REG_NEIGHBOR_COUNT: return 32'(reg_nk);
            pcfc_pkg::REG_POS_DIMS:       return 32'(reg_dims);
            default:                      return '0;
         endcase
      endfunction

      // update stores, or queue the outputs of a compute
      function void note_input(pcfc_pkg::pcfc_req_type r);
         int pt, k, c, o, s, i, d, si, bi, fi, pi, ni;
         longint acc, w, f, delta, th;
         conv_result_type e;
         pt = int'(r.point);
         items++;
         case (r.command)
            pcfc_pkg::OP_FEATURE: begin
               fi = int'(r.in_channel) * pcfc_pkg::MAX_POINTS + pt;
               feat_mem[fi] = r.value;
               feat_set[fi] = 1;
            end
            pcfc_pkg::OP_POSITION: if (r.coord < pcfc_pkg::MAX_POS_DIMS) begin
               pi = int'(r.coord) * pcfc_pkg::MAX_POINTS + pt;
               pos_mem[pi] = r.value;
               pos_set[pi] = 1;
            end
            pcfc_pkg::OP_NEIGHBOR: begin
               ni = int'(r.slot) * pcfc_pkg::MAX_POINTS + pt;
               nbr_mem[ni] = r.value[9:0];
               nbr_set[ni] = 1;
            end
            pcfc_pkg::OP_SLOPE: if (r.coord < pcfc_pkg::MAX_POS_DIMS) begin
               si = (int'(r.coord) * pcfc_pkg::MAX_IN_CHANNELS + int'(r.in_channel))
                    * pcfc_pkg::MAX_OUT_CHANNELS + int'(r.out_channel);
               slope_mem[si] = r.value;
               slope_set[si] = 1;
            end
            pcfc_pkg::OP_BIAS: begin
               bi = int'(r.in_channel) * pcfc_pkg::MAX_OUT_CHANNELS + int'(r.out_channel);
               bias_mem[bi] = r.value;
               bias_set[bi] = 1;
            end
            pcfc_pkg::OP_COMPUTE: begin
               computes++;
               c = int'(nbr_mem[pt]);
               for (o = 0; o < n_out(); o++) begin
                  acc = 0;
                  for (s = 0; s < n_nk(); s++) begin
                     k = int'(nbr_mem[s * pcfc_pkg::MAX_POINTS + pt]);
                     for (i = 0; i < n_in(); i++) begin
                        bi = i * pcfc_pkg::MAX_OUT_CHANNELS + o;
                        w = longint'(bias_mem[bi]);
                        f = longint'(feat_mem[i * pcfc_pkg::MAX_POINTS + k]);
                        for (d = 0; d < n_dims(); d++) begin
                           delta = longint'(pos_mem[d * pcfc_pkg::MAX_POINTS + k])
                                   - longint'(pos_mem[d * pcfc_pkg::MAX_POINTS + c]);
                           delta = sat_word(delta);
                           si = (d * pcfc_pkg::MAX_IN_CHANNELS + i)
                                * pcfc_pkg::MAX_OUT_CHANNELS + o;
                           th = longint'(slope_mem[si]);
                           w += (th * delta) >>> 16;
                        end
                        w = sat_word(w);
                        acc += (w * f) >>> 16;
                     end
                  end
                  e.pt = 10'(pt);
                  e.och = 4'(o);
                  e.val = 32'(sat_word(acc));
                  e.last = (o + 1 == n_out());
                  owed_q.push_back(e);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(conv_result_type got);
         conv_result_type e;
         results++;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected result point %0d channel %0d value %h",
                     $time, got.pt, got.och, got.val);
            errors++;
            return;
         end
         e = owed_q.pop_front();
         if (got.pt !== e.pt) begin
            $display("%0t: point_res expected %0d actual %0d", $time, e.pt, got.pt);
            errors++;
         end
         if (got.och !== e.och) begin
            $display("%0t: out_channel_res expected %0d actual %0d", $time, e.och, got.och);
            errors++;
         end
         if (got.val !== e.val) begin
            $display("%0t: result_value expected %h actual %h", $time, e.val, got.val);
            errors++;
         end
         if (got.last !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   bit          calm = 0;
   bit          hold_now = 0;
   bit          long_hold_done = 0;
   int          pool [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 341, 512, 682, 1023};
   flex_conv_scoreboard sb = new();

   pcfc_req_if req_bus();
   pcfc_rsp_if rsp_bus();

   point_cloud_flex_conv_forward u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #2 clock = ~clock;

   initial begin
      req_bus.valid = 0;
      req_bus.command = pcfc_pkg::OP_FEATURE;
      req_bus.point = '0;
      req_bus.slot = '0;
      req_bus.in_channel = '0;
      req_bus.out_channel = '0;
      req_bus.coord = '0;
      req_bus.value = '0;
      rsp_bus.ready = 0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      if (r < 6) return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      return $urandom();
   endfunction

   function automatic logic [31:0] pick_link();
      logic [31:0] v;
      v = $urandom();
      v[9:0] = 10'(pool[$urandom_range(0, 11)]);
      return v;
   endfunction

   // result channel: random back-pressure, one long hold-off
   initial begin
      int stall_left;
      stall_left = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!long_hold_done && hold_now) begin
            long_hold_done = 1;
            stall_left = 3000;
         end
         if (stall_left > 0) begin
            rsp_bus.ready = 0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready = 0;
            stall_left = pick_gap();
         end else begin
            rsp_bus.ready = 1;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      conv_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.pt = rsp_bus.point_res;
         got.och = rsp_bus.out_channel_res;
         got.val = rsp_bus.result_value;
         got.last = rsp_bus.last;
         sb.check_result(got);
      end
   end

   // one command transfer, then an optional gap
   task automatic send_cmd(logic [2:0] op, logic [9:0] pt, logic [2:0] sl,
                           logic [3:0] ic, logic [3:0] oc, logic [1:0] cd,
                           logic [31:0] v);
      pcfc_pkg::pcfc_req_type r;
      int gap;
      r.command = op; r.point = pt; r.slot = sl; r.in_channel = ic;
      r.out_channel = oc; r.coord = cd; r.value = v;
      @(negedge clock);
      req_bus.valid = 1;
      req_bus.command = op;
      req_bus.point = pt;
      req_bus.slot = sl;
      req_bus.in_channel = ic;
      req_bus.out_channel = oc;
      req_bus.coord = cd;
      req_bus.value = v;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_input(r);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid = 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic send_write(logic [2:0] op, int pt, int sl, int ic, int oc, int cd,
                             logic [31:0] v);
      send_cmd(op, 10'(pt), 3'(sl), 4'(ic), 4'(oc), 2'(cd), v);
   endtask

   // register write, then a read-back of the same register
   task automatic csr_write(pcfc_pkg::pcfc_reg_type idx, logic [31:0] v);
      @(negedge clock);
      psel = 1; penable = 0; pwrite = 1;
      paddr = {idx, 2'b00};
      pwdata = v;
      @(negedge clock);
      penable = 1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, v);
      @(negedge clock);
      penable = 0; pwrite = 0;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      if (prdata !== sb.reg_value(idx)) begin
         $display("%0t: register %0d expected %h actual %h", $time, idx,
                  sb.reg_value(idx), prdata);
         sb.errors++;
      end
      @(negedge clock);
      psel = 0; penable = 0;
   endtask

   // withdraw the offered command, then wait for every owed result
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 0;
      while (sb.owed_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(logic [31:0] nin, logic [31:0] nout, logic [31:0] nk,
                             logic [31:0] nd);
      wait_drained();
      repeat (64) @(posedge clock);
      csr_write(pcfc_pkg::REG_IN_CHANNELS, nin);
      csr_write(pcfc_pkg::REG_OUT_CHANNELS, nout);
      csr_write(pcfc_pkg::REG_NEIGHBOR_COUNT, nk);
      csr_write(pcfc_pkg::REG_POS_DIMS, nd);
   endtask

   // fill every entry that a compute of this point will read
   task automatic prime_point(int pt);
      int s, i, d, o, k, idx;
      for (s = 0; s < sb.n_nk(); s++)
         if (!sb.nbr_set[s * pcfc_pkg::MAX_POINTS + pt])
            send_write(pcfc_pkg::OP_NEIGHBOR, pt, s, $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 3), pick_link());
      for (s = 0; s < sb.n_nk(); s++) begin
         k = int'(sb.nbr_mem[s * pcfc_pkg::MAX_POINTS + pt]);
         for (i = 0; i < sb.n_in(); i++)
            if (!sb.feat_set[i * pcfc_pkg::MAX_POINTS + k])
               send_write(pcfc_pkg::OP_FEATURE, k, $urandom_range(0, 7), i,
                          $urandom_range(0, 15), $urandom_range(0, 3), pick_value());
         for (d = 0; d < sb.n_dims(); d++)
            if (!sb.pos_set[d * pcfc_pkg::MAX_POINTS + k])
               send_write(pcfc_pkg::OP_POSITION, k, $urandom_range(0, 7),
                          $urandom_range(0, 15), $urandom_range(0, 15), d, pick_value());
      end
      for (o = 0; o < sb.n_out(); o++)
         for (i = 0; i < sb.n_in(); i++) begin
            if (!sb.bias_set[i * pcfc_pkg::MAX_OUT_CHANNELS + o])
               send_write(pcfc_pkg::OP_BIAS, $urandom_range(0, 1023), $urandom_range(0, 7),
                          i, o, $urandom_range(0, 3), pick_value());
            for (d = 0; d < sb.n_dims(); d++) begin
               idx = (d * pcfc_pkg::MAX_IN_CHANNELS + i) * pcfc_pkg::MAX_OUT_CHANNELS + o;
               if (!sb.slope_set[idx])
                  send_write(pcfc_pkg::OP_SLOPE, $urandom_range(0, 1023),
                             $urandom_range(0, 7), i, o, d, pick_value());
            end
         end
   endtask

   task automatic run_compute(int pt);
      prime_point(pt);
      send_write(pcfc_pkg::OP_COMPUTE, pt, $urandom_range(0, 7), $urandom_range(0, 15),
                 $urandom_range(0, 15), $urandom_range(0, 3), $urandom());
   endtask

   // run limit
   initial begin
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // stimulus
   initial begin
      int ph, it, r, budget;
      repeat (10) @(negedge clock);
      reset = 0;

      // directed: extremes, ignored writes, spare commands
      send_write(pcfc_pkg::OP_FEATURE, 1023, 0, 15, 0, 0, 32'h7FFF_FFFF);
      send_write(pcfc_pkg::OP_FEATURE, 0, 7, 0, 15, 3, 32'h8000_0000);
      send_write(pcfc_pkg::OP_POSITION, 1023, 0, 0, 0, COORD_SPARE, 32'h1234_5678);
      send_write(pcfc_pkg::OP_SLOPE, 1023, 0, 15, 15, COORD_SPARE, 32'hDEAD_BEEF);
      send_write(OP_SPARE_A, 1023, 7, 15, 15, 3, 32'hFFFF_FFFF);
      send_write(OP_SPARE_B, 0, 0, 0, 0, 0, 32'h0);
      send_write(pcfc_pkg::OP_NEIGHBOR, 1023, 7, 0, 0, 0, 32'hFFFF_FFFF);
      send_write(pcfc_pkg::OP_BIAS, 0, 0, 15, 15, 0, 32'h8000_0000);
      send_write(pcfc_pkg::OP_SLOPE, 0, 0, 15, 15, 2, 32'h7FFF_FFFF);

      // all sixteen output channels in one compute
      set_config(1, 16, 1, 1);
      run_compute(1023);

      // zero registers act as one; delta saturates in both directions
      set_config(0, 0, 0, 0);
      send_write(pcfc_pkg::OP_NEIGHBOR, 5, 0, 0, 0, 0, 32'hFFFF_FC06);
      send_write(pcfc_pkg::OP_NEIGHBOR, 5, 1, 0, 0, 0, 32'h0000_0007);
      send_write(pcfc_pkg::OP_POSITION, 6, 0, 0, 0, 0, 32'h8000_0000);
      send_write(pcfc_pkg::OP_POSITION, 7, 0, 0, 0, 0, 32'h7FFF_FFFF);
      send_write(pcfc_pkg::OP_NEIGHBOR, 8, 0, 0, 0, 0, 32'h0000_0007);
      send_write(pcfc_pkg::OP_NEIGHBOR, 8, 1, 0, 0, 0, 32'h0000_0006);
      run_compute(5);
      set_config(1, 1, 2, 1);
      run_compute(5);
      run_compute(8);

      // random phases; the second has registers beyond their maximum and the long hold-off
      for (ph = 0; ph < 4; ph++) begin
         if (ph == 1) set_config(1, 31, 15, 1);
         else set_config($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 3),
                         $urandom_range(0, 3));
         budget = (ph == 1) ? 0 : 100;
         for (it = 0; it < 10; it++) begin
            calm = (ph == 2 && it < 4);
            if (ph == 3 && it == 5) wait_drained();
            r = $urandom_range(0, 99);
            if (ph == 1 && it == 0) begin
               run_compute(pool[$urandom_range(0, 11)]);
               hold_now = 1;
            end else if (r < 22 && budget > 0) begin
               budget--;
               run_compute(pool[$urandom_range(0, 11)]);
            end else if (r < 30) begin
               send_write($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                          $urandom_range(0, 1023), $urandom_range(0, 7),
                          $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 3), $urandom());
            end else if (r < 36) begin
               send_write(3'($urandom_range(0, 4)), $urandom_range(0, 1023),
                          $urandom_range(0, 7), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 3), pick_value());
            end else begin
               r = $urandom_range(0, 4);
               send_write(3'(r), pool[$urandom_range(0, 11)], $urandom_range(0, 7),
                          $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 3),
                          (r == int'(pcfc_pkg::OP_NEIGHBOR)) ? pick_link() : pick_value());
            end
         end
      end
      calm = 0;

      wait_drained();
      repeat (200) @(posedge clock);
      $display("Run covered %0d commands, %0d computes and %0d checked outputs",
               sb.items, sb.computes, sb.results);
      $display("with zero, in-range and over-range registers, a long hold-off and a drain.");
      if (sb.errors == 0 && sb.owed_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/pcfc_pkg.sv
rtl/core/pcfc_req_if.sv
rtl/core/pcfc_rsp_if.sv
rtl/core/pcfc_dpath.sv
rtl/core/pcfc_ctrl.sv
rtl/core/point_cloud_flex_conv_forward.sv
tb/sv/point_cloud_flex_conv_forward_tb.sv
